@@ rtl/core/lcdspi_pkg.sv @@
// Shared types, codes and the init ROM of the LCD serial command sequencer.
package lcdspi_pkg;

   localparam int unsigned WORD_WIDTH  = 16;
   localparam int unsigned INDEX_WIDTH = 6;

   localparam logic [2:0] MODE_CMD    = 3'd0;
   localparam logic [2:0] MODE_DATA   = 3'd1;
   localparam logic [2:0] MODE_WORD   = 3'd2;
   localparam logic [2:0] MODE_WINDOW = 3'd3;
   localparam logic [2:0] MODE_INIT   = 3'd4;

   localparam logic [1:0] KIND_CMD  = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_WAIT = 2'd2;

   localparam logic [1:0] ORIENT_OFFSET_Y = 2'd1;
   localparam logic [1:0] ORIENT_OFFSET_X = 2'd3;

   localparam logic [7:0] CMD_CASET = 8'h2A;
   localparam logic [7:0] CMD_RASET = 8'h2B;
   localparam logic [7:0] CMD_RAMWR = 8'h2C;

   localparam logic [INDEX_WIDTH-1:0] INIT_MAC_SLOT = 6'd5;
   localparam logic [INDEX_WIDTH-1:0] INIT_LAST     = 6'd60;
   localparam logic [INDEX_WIDTH-1:0] WINDOW_LAST   = 6'd10;
   localparam logic [INDEX_WIDTH-1:0] WORD_LAST     = 6'd1;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] frame_byte;
   } frame_type;

   function automatic logic [7:0] mac_byte(input logic [1:0] orientation);
      logic [7:0] result;
      unique case (orientation)
         2'd0: result = 8'h00;
         2'd1: result = 8'hC0;
         2'd2: result = 8'h70;
         2'd3: result = 8'hA0;
         default: result = 8'h00;
      endcase
      return result;
   endfunction

   function automatic frame_type init_rom(input logic [INDEX_WIDTH-1:0] index);
      frame_type f;
      f.kind = KIND_DATA;
      unique case (index)
         6'd0:  f = '{KIND_CMD,  8'h11};
         6'd1:  f = '{KIND_WAIT, 8'd120};
         6'd2:  f = '{KIND_CMD,  8'h11};
         6'd3:  f = '{KIND_WAIT, 8'd120};
         6'd4:  f = '{KIND_CMD,  8'h36};
         6'd5:  f = '{KIND_DATA, 8'h00};
         6'd6:  f = '{KIND_CMD,  8'h3A};
         6'd7:  f = '{KIND_DATA, 8'h05};
         6'd8:  f = '{KIND_CMD,  8'hB2};
         6'd9:  f = '{KIND_DATA, 8'h0C};
         6'd10: f = '{KIND_DATA, 8'h0C};
         6'd11: f = '{KIND_DATA, 8'h00};
         6'd12: f = '{KIND_DATA, 8'h33};
         6'd13: f = '{KIND_DATA, 8'h33};
         6'd14: f = '{KIND_CMD,  8'hB7};
         6'd15: f = '{KIND_DATA, 8'h35};
         6'd16: f = '{KIND_CMD,  8'hBB};
         6'd17: f = '{KIND_DATA, 8'h32};
         6'd18: f = '{KIND_CMD,  8'hC2};
         6'd19: f = '{KIND_DATA, 8'h01};
         6'd20: f = '{KIND_CMD,  8'hC3};
         6'd21: f = '{KIND_DATA, 8'h15};
         6'd22: f = '{KIND_CMD,  8'hC4};
         6'd23: f = '{KIND_DATA, 8'h20};
         6'd24: f = '{KIND_CMD,  8'hC6};
         6'd25: f = '{KIND_DATA, 8'h0F};
         6'd26: f = '{KIND_CMD,  8'hD0};
         6'd27: f = '{KIND_DATA, 8'hA4};
         6'd28: f = '{KIND_DATA, 8'hA1};
         6'd29: f = '{KIND_CMD,  8'hE0};
         6'd30: f = '{KIND_DATA, 8'hD0};
         6'd31: f = '{KIND_DATA, 8'h08};
         6'd32: f = '{KIND_DATA, 8'h0E};
         6'd33: f = '{KIND_DATA, 8'h09};
         6'd34: f = '{KIND_DATA, 8'h09};
         6'd35: f = '{KIND_DATA, 8'h05};
         6'd36: f = '{KIND_DATA, 8'h31};
         6'd37: f = '{KIND_DATA, 8'h33};
         6'd38: f = '{KIND_DATA, 8'h48};
         6'd39: f = '{KIND_DATA, 8'h17};
         6'd40: f = '{KIND_DATA, 8'h14};
         6'd41: f = '{KIND_DATA, 8'h15};
         6'd42: f = '{KIND_DATA, 8'h31};
         6'd43: f = '{KIND_DATA, 8'h34};
         6'd44: f = '{KIND_CMD,  8'hE1};
         6'd45: f = '{KIND_DATA, 8'hD0};
         6'd46: f = '{KIND_DATA, 8'h08};
         6'd47: f = '{KIND_DATA, 8'h0E};
         6'd48: f = '{KIND_DATA, 8'h09};
         6'd49: f = '{KIND_DATA, 8'h09};
         6'd50: f = '{KIND_DATA, 8'h15};
         6'd51: f = '{KIND_DATA, 8'h31};
         6'd52: f = '{KIND_DATA, 8'h33};
         6'd53: f = '{KIND_DATA, 8'h48};
         6'd54: f = '{KIND_DATA, 8'h17};
         6'd55: f = '{KIND_DATA, 8'h14};
         6'd56: f = '{KIND_DATA, 8'h15};
         6'd57: f = '{KIND_DATA, 8'h31};
         6'd58: f = '{KIND_DATA, 8'h34};
         6'd59: f = '{KIND_CMD,  8'h21};
         6'd60: f = '{KIND_CMD,  8'h29};
         default: f = '{KIND_CMD, 8'h00};
      endcase
      return f;
   endfunction

endpackage

@@ rtl/core/lcdspi_ifs.sv @@
// Valid/ready channel interfaces for requests and frame items.
interface lcdspi_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [15:0] value;
   logic [15:0] x_start;
   logic [15:0] y_start;
   logic [15:0] x_end;
   logic [15:0] y_end;

   modport source (output valid, mode, value, x_start, y_start, x_end, y_end, input ready);
   modport sink   (input valid, mode, value, x_start, y_start, x_end, y_end, output ready);
endinterface

interface lcdspi_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] frame_byte;
   logic       last;

   modport source (output valid, kind, frame_byte, last, input ready);
   modport sink   (input valid, kind, frame_byte, last, output ready);
endinterface

@@ rtl/core/lcdspi_ser_add.sv @@
// Bit-serial adder lane that adds a serial addend to a loaded word, LSB first.
module lcdspi_ser_add #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             load,
   input  logic [WIDTH-1:0] load_value,
   input  logic             shift,
   input  logic             addend_bit,
   output logic [WIDTH-1:0] sum
);

   logic [WIDTH-1:0] word_ff;
   logic [WIDTH-1:0] word_in;
   logic             carry_ff;
   logic             carry_in;
   logic             sum_bit;

   assign sum_bit = word_ff[0] ^ addend_bit ^ carry_ff;

   always_comb begin
      word_in  = word_ff;
      carry_in = carry_ff;
      if (load) begin
         word_in  = load_value;
         carry_in = 1'b0;
      end else if (shift) begin
         word_in  = {sum_bit, word_ff[WIDTH-1:1]};
         carry_in = (word_ff[0] & addend_bit) | (carry_ff & (word_ff[0] ^ addend_bit));
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      carry_ff <= carry_in;
   end

   assign sum = word_ff;

endmodule

@@ rtl/core/lcd_spi_command_sequencer_core.sv @@
// Top level of the LCD serial command sequencer: request decode, offset add and frame output.
// Each accepted request of a used mode becomes one or more frame items, one per cycle while
// the output register is free. A command or data byte request emits one frame, a data word
// request two; a window request first adds the address offset to its x or y coordinates,
// as the orientation selects, through two bit-serial adder lanes, then emits 11 frames;
// the init request emits its 61 ROM frames. Requests with an unused mode are taken and
// produce nothing. A new request is accepted as soon as the final frame of the previous
// one sits in the output register.
module lcd_spi_command_sequencer_core #(
   parameter int ADDRESS_OFFSET = 80
) (
   input  logic              clock,
   input  logic              reset,
   lcdspi_req_if.sink        req,
   lcdspi_rsp_if.source      rsp,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_write_data
);

   localparam int unsigned W = lcdspi_pkg::WORD_WIDTH;
   localparam int unsigned CNT_W = $clog2(W);
   localparam logic [W-1:0] OFFSET_WORD = W'(ADDRESS_OFFSET);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_EMIT
   } state_type;

   state_type  state_ff;
   logic [1:0] orientation_ff;
   logic [2:0] mode_ff;
   logic [W-1:0] value_ff;
   logic [W-1:0] xs_ff;
   logic [W-1:0] ys_ff;
   logic [W-1:0] xe_ff;
   logic [W-1:0] ye_ff;
   logic [W-1:0] addend_ff;
   logic [CNT_W-1:0] bit_cnt_ff;
   logic [lcdspi_pkg::INDEX_WIDTH-1:0] idx_ff;
   logic       rsp_valid_ff;
   logic [1:0] rsp_kind_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;

   logic accept;
   logic load_out;
   logic lane_load;
   logic lane_shift;
   logic offset_x;
   logic offset_y;
   logic [W-1:0] lane_start;
   logic [W-1:0] lane_end;
   logic [W-1:0] x_start_word;
   logic [W-1:0] x_end_word;
   logic [W-1:0] y_start_word;
   logic [W-1:0] y_end_word;
   lcdspi_pkg::frame_type frame;
   lcdspi_pkg::frame_type rom_frame;
   logic frame_last;

   assign req.ready  = (state_ff == ST_IDLE);
   assign accept     = req.valid && req.ready;
   assign load_out   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp.ready);
   assign lane_load  = accept;
   assign lane_shift = (state_ff == ST_ADD);
   assign offset_x   = (orientation_ff == lcdspi_pkg::ORIENT_OFFSET_X);
   assign offset_y   = (orientation_ff == lcdspi_pkg::ORIENT_OFFSET_Y);

   lcdspi_ser_add #(.WIDTH(W)) u_add_start (
      .clock      (clock),
      .load       (lane_load),
      .load_value (offset_x ? req.x_start : req.y_start),
      .shift      (lane_shift),
      .addend_bit (addend_ff[0]),
      .sum        (lane_start)
   );

   lcdspi_ser_add #(.WIDTH(W)) u_add_end (
      .clock      (clock),
      .load       (lane_load),
      .load_value (offset_x ? req.x_end : req.y_end),
      .shift      (lane_shift),
      .addend_bit (addend_ff[0]),
      .sum        (lane_end)
   );

   assign x_start_word = offset_x ? lane_start : xs_ff;
   assign x_end_word   = offset_x ? lane_end   : xe_ff;
   assign y_start_word = offset_y ? lane_start : ys_ff;
   assign y_end_word   = offset_y ? lane_end   : ye_ff;

   always_comb begin
      rom_frame = lcdspi_pkg::init_rom(idx_ff);
      if (idx_ff == lcdspi_pkg::INIT_MAC_SLOT) begin
         rom_frame.frame_byte = lcdspi_pkg::mac_byte(orientation_ff);
      end
   end

   always_comb begin
      frame.kind       = lcdspi_pkg::KIND_DATA;
      frame.frame_byte = 8'h00;
      frame_last       = 1'b1;
      unique case (mode_ff)
         lcdspi_pkg::MODE_CMD: begin
            frame.kind       = lcdspi_pkg::KIND_CMD;
            frame.frame_byte = value_ff[7:0];
         end
         lcdspi_pkg::MODE_DATA: begin
            frame.frame_byte = value_ff[7:0];
         end
         lcdspi_pkg::MODE_WORD: begin
            frame.frame_byte = idx_ff[0] ? value_ff[7:0] : value_ff[15:8];
            frame_last       = (idx_ff == lcdspi_pkg::WORD_LAST);
         end
         lcdspi_pkg::MODE_WINDOW: begin
            frame_last = (idx_ff == lcdspi_pkg::WINDOW_LAST);
            unique case (idx_ff[3:0])
               4'd0: begin
                  frame.kind       = lcdspi_pkg::KIND_CMD;
                  frame.frame_byte = lcdspi_pkg::CMD_CASET;
               end
               4'd1: frame.frame_byte = x_start_word[15:8];
               4'd2: frame.frame_byte = x_start_word[7:0];
               4'd3: frame.frame_byte = x_end_word[15:8];
               4'd4: frame.frame_byte = x_end_word[7:0];
               4'd5: begin
                  frame.kind       = lcdspi_pkg::KIND_CMD;
                  frame.frame_byte = lcdspi_pkg::CMD_RASET;
               end
               4'd6: frame.frame_byte = y_start_word[15:8];
               4'd7: frame.frame_byte = y_start_word[7:0];
               4'd8: frame.frame_byte = y_end_word[15:8];
               4'd9: frame.frame_byte = y_end_word[7:0];
               default: begin
                  frame.kind       = lcdspi_pkg::KIND_CMD;
                  frame.frame_byte = lcdspi_pkg::CMD_RAMWR;
               end
            endcase
         end
         lcdspi_pkg::MODE_INIT: begin
            frame      = rom_frame;
            frame_last = (idx_ff == lcdspi_pkg::INIT_LAST);
         end
         default: begin
            frame.kind = lcdspi_pkg::KIND_CMD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         orientation_ff <= 2'd0;
         rsp_valid_ff   <= 1'b0;
         idx_ff         <= '0;
         bit_cnt_ff     <= '0;
      end else begin
         if (csr_write_enable) begin
            orientation_ff <= csr_write_data;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  idx_ff     <= '0;
                  bit_cnt_ff <= '0;
                  if (req.mode == lcdspi_pkg::MODE_WINDOW) begin
                     state_ff <= ST_ADD;
                  end else if (req.mode <= lcdspi_pkg::MODE_INIT) begin
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_ADD: begin
               bit_cnt_ff <= bit_cnt_ff + 1'b1;
               if (bit_cnt_ff == CNT_W'(W - 1)) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (load_out) begin
                  rsp_kind_ff  <= frame.kind;
                  rsp_byte_ff  <= frame.frame_byte;
                  rsp_last_ff  <= frame_last;
                  idx_ff       <= idx_ff + 1'b1;
                  if (frame_last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req.mode;
         value_ff  <= req.value;
         xs_ff     <= req.x_start;
         ys_ff     <= req.y_start;
         xe_ff     <= req.x_end;
         ye_ff     <= req.y_end;
         addend_ff <= (offset_x || offset_y) ? OFFSET_WORD : '0;
      end else if (lane_shift) begin
         addend_ff <= {1'b0, addend_ff[W-1:1]};
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.kind       = rsp_kind_ff;
   assign rsp.frame_byte = rsp_byte_ff;
   assign rsp.last       = rsp_last_ff;

   a_unused_mode_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req.mode > lcdspi_pkg::MODE_INIT) |=> !$rose(rsp.valid))
      else $error("frame produced for an unused mode");

   a_last_frees_input: assert property (@(posedge clock) disable iff (reset)
      (load_out && frame_last) |=> req.ready)
      else $error("input not ready after final frame");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (idx_ff <= lcdspi_pkg::INIT_LAST))
      else $error("frame index beyond init sequence");

   a_wait_only_in_init: assert property (@(posedge clock) disable iff (reset)
      (load_out && frame.kind == lcdspi_pkg::KIND_WAIT) |-> (mode_ff == lcdspi_pkg::MODE_INIT))
      else $error("wait frame outside init sequence");

endmodule
